FILE: rtl/core/pmx_pkg.sv
// ----------------------------------------------------------------------------
// pmx_pkg
// Shared types and constants of the max / average pooling block.
// ----------------------------------------------------------------------------
`default_nettype none

package pmx_pkg;

    localparam int unsigned MAX_WINDOW   = 8;
    localparam int unsigned MAX_OUT_COLS = 256;
    localparam int unsigned ACC_W        = 23;
    localparam int unsigned WIN_W        = 16;
    localparam int unsigned WORD_W       = ACC_W + WIN_W;
    localparam int unsigned ADDR_W       = $clog2(MAX_WINDOW * MAX_OUT_COLS);

    localparam logic [2:0] REG_POOL_MODE     = 3'd0;
    localparam logic [2:0] REG_WINDOW_HEIGHT = 3'd1;
    localparam logic [2:0] REG_WINDOW_WIDTH  = 3'd2;
    localparam logic [2:0] REG_STEP_ROWS     = 3'd3;
    localparam logic [2:0] REG_STEP_COLS     = 3'd4;
    localparam logic [2:0] REG_OUT_ROWS      = 3'd5;
    localparam logic [2:0] REG_OUT_COLS      = 3'd6;

    localparam logic MODE_MAX = 1'b0;
    localparam logic MODE_AVG = 1'b1;

    localparam logic [7:0] LAST_IN_COL = 8'd255;
    localparam logic [7:0] LAST_IN_ROW = 8'd255;

    typedef struct packed {
        logic       mode;
        logic [3:0] kh;
        logic [3:0] kw;
        logic [3:0] sr;
        logic [3:0] sc;
        logic [8:0] orows;
        logic [8:0] ocols;
    } cfg_t;

    typedef struct packed {
        logic [15:0] value;
        logic [15:0] win;
        logic [7:0]  row;
        logic [7:0]  col;
        logic        plane_done;
        logic        run_last;
    } res_t;

endpackage

`default_nettype wire

FILE: rtl/core/pooling_max_avg_with_argmax.sv
// ----------------------------------------------------------------------------
// pooling_max_avg_with_argmax
// Streaming 2-D max / average pooling of one feature-map plane with argmax.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order; each request is handled alone. A request
// first finds its window bounds with four reciprocal divisions on one shared
// multiplier. For every window the pixel touches it then does one read and
// one write of the single-port slot memory, and for every window it completes
// a reciprocal multiply for the average. A pixel touches up to
// window_height x window_width windows. Results leave through an output
// register, so the next pixel is taken while a result still waits.
`default_nettype none

module pooling_max_avg_with_argmax (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] pixel_value,
    input  wire logic        row_end,
    input  wire logic        plane_end,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [15:0] pooled_value,
    output logic      [15:0] winner_position,
    output logic      [7:0]  out_row,
    output logic      [7:0]  out_col,
    output logic             plane_done,
    output logic             run_last
);

    logic       mode_reg;
    logic [3:0] kh_reg, kw_reg, sr_reg, sc_reg;
    logic [8:0] orows_reg, ocols_reg;
    logic       wr_en;
    logic [2:0] reg_idx;
    pmx_pkg::cfg_t cfg;
    pmx_pkg::res_t res;

    function automatic logic [3:0] clamp_small(input logic [3:0] v);
        logic [3:0] r;
        if (v == 4'd0)
        begin
            r = 4'd1;
        end
        else if (v > 4'(pmx_pkg::MAX_WINDOW))
        begin
            r = 4'(pmx_pkg::MAX_WINDOW);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [8:0] clamp_count(input logic [8:0] v);
        logic [8:0] r;
        if (v == 9'd0)
        begin
            r = 9'd1;
        end
        else if (v > 9'd256)
        begin
            r = 9'd256;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= pmx_pkg::MODE_MAX;
            kh_reg    <= 4'd2;
            kw_reg    <= 4'd2;
            sr_reg    <= 4'd2;
            sc_reg    <= 4'd2;
            orows_reg <= 9'd1;
            ocols_reg <= 9'd1;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                pmx_pkg::REG_POOL_MODE:     mode_reg  <= pwdata[0];
                pmx_pkg::REG_WINDOW_HEIGHT: kh_reg    <= pwdata[3:0];
                pmx_pkg::REG_WINDOW_WIDTH:  kw_reg    <= pwdata[3:0];
                pmx_pkg::REG_STEP_ROWS:     sr_reg    <= pwdata[3:0];
                pmx_pkg::REG_STEP_COLS:     sc_reg    <= pwdata[3:0];
                pmx_pkg::REG_OUT_ROWS:      orows_reg <= pwdata[8:0];
                pmx_pkg::REG_OUT_COLS:      ocols_reg <= pwdata[8:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            pmx_pkg::REG_POOL_MODE:     prdata = {31'd0, mode_reg};
            pmx_pkg::REG_WINDOW_HEIGHT: prdata = {28'd0, kh_reg};
            pmx_pkg::REG_WINDOW_WIDTH:  prdata = {28'd0, kw_reg};
            pmx_pkg::REG_STEP_ROWS:     prdata = {28'd0, sr_reg};
            pmx_pkg::REG_STEP_COLS:     prdata = {28'd0, sc_reg};
            pmx_pkg::REG_OUT_ROWS:      prdata = {23'd0, orows_reg};
            pmx_pkg::REG_OUT_COLS:      prdata = {23'd0, ocols_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        cfg.mode  = mode_reg;
        cfg.kh    = clamp_small(kh_reg);
        cfg.kw    = clamp_small(kw_reg);
        cfg.sr    = clamp_small(sr_reg);
        cfg.sc    = clamp_small(sc_reg);
        cfg.orows = clamp_count(orows_reg);
        cfg.ocols = clamp_count(ocols_reg);
    end

    pmx_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_value (pixel_value),
        .row_end     (row_end),
        .plane_end   (plane_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .res         (res)
    );

    assign pooled_value    = res.value;
    assign winner_position = res.win;
    assign out_row         = res.row;
    assign out_col         = res.col;
    assign plane_done      = res.plane_done;
    assign run_last        = res.run_last;

    a_busy_after_request: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall
    ) else $error("engine did not go busy after a request");

    a_stall_only_on_request: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid)
    ) else $error("input stalled without a request");

endmodule

`default_nettype wire

FILE: rtl/core/pmx_slot_mem.sv
// ----------------------------------------------------------------------------
// pmx_slot_mem
// Window slot store: accumulator and winner position, one read, one write.
// ----------------------------------------------------------------------------
`default_nettype none

module pmx_slot_mem (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [pmx_pkg::ADDR_W-1:0] wr_addr,
    input  wire logic [pmx_pkg::WORD_W-1:0] wr_data,
    input  wire logic                       rd_en,
    input  wire logic [pmx_pkg::ADDR_W-1:0] rd_addr,
    output logic      [pmx_pkg::WORD_W-1:0] rd_data
);

    logic [pmx_pkg::WORD_W-1:0] mem [2**pmx_pkg::ADDR_W];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/pmx_engine.sv
// ----------------------------------------------------------------------------
// pmx_engine
// Per-pixel sequencer: window bounds, slot read-modify-write, result output.
// ----------------------------------------------------------------------------
`default_nettype none

module pmx_engine (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire pmx_pkg::cfg_t cfg,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [15:0]   pixel_value,
    input  wire logic          row_end,
    input  wire logic          plane_end,
    output logic               out_valid,
    input  wire logic          out_stall,
    output pmx_pkg::res_t      res
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_BND  = 3'd1;
    localparam logic [2:0] S_SET  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_MOD  = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;
    localparam logic [2:0] S_PUSH = 3'd6;
    localparam logic [2:0] S_END  = 3'd7;

    logic [16:0] step_recip [16];
    logic [29:0] area_recip [128];

    for (genvar g = 0; g < 16; g++)
    begin : g_srec
        localparam int unsigned D  = (g == 0) ? 1 : g;
        localparam logic [16:0] RV = 17'((65536 + D - 1) / D);
        assign step_recip[g] = RV;
    end

    for (genvar g = 0; g < 128; g++)
    begin : g_arec
        localparam int unsigned D  = (g == 0) ? 1 : g;
        localparam logic [29:0] RV = 30'((536870912 + D - 1) / D);
        assign area_recip[g] = RV;
    end

    logic [2:0]  state_reg, state_next;
    logic [1:0]  bstep_reg, bstep_next;
    logic [7:0]  row_cnt_reg, row_cnt_next;
    logic [7:0]  col_cnt_reg, col_cnt_next;
    logic [8:0]  lrw_reg, lrw_next;
    logic [15:0] val_reg, val_next;
    logic [7:0]  r_reg, r_next;
    logic [7:0]  c_reg, c_next;
    logic        rl_reg, rl_next;
    logic        pe_reg, pe_next;
    logic [7:0]  ph_hi_reg, ph_hi_next;
    logic [7:0]  ph_lo_reg, ph_lo_next;
    logic [7:0]  pw_hi_reg, pw_hi_next;
    logic [7:0]  pw_lo_reg, pw_lo_next;
    logic [7:0]  ph_end_reg, ph_end_next;
    logic [7:0]  pw_end_reg, pw_end_next;
    logic [7:0]  ph_reg, ph_next;
    logic [7:0]  pw_reg, pw_next;
    logic [11:0] hs_reg, hs_next;
    logic [11:0] ws_reg, ws_next;
    logic [11:0] ws_lo_reg, ws_lo_next;
    logic [15:0] pos_reg, pos_next;
    logic        last_reg, last_next;
    logic [22:0] cacc_reg, cacc_next;
    logic [15:0] cwin_reg, cwin_next;
    logic [7:0]  cph_reg, cph_next;
    logic [7:0]  cpw_reg, cpw_next;
    logic        cpd_reg, cpd_next;
    logic [6:0]  area_reg, area_next;
    logic [52:0] prod_reg, prod_next;
    logic        have_reg, have_next;
    pmx_pkg::res_t pend_reg, pend_next;
    logic        out_valid_reg, out_valid_next;
    pmx_pkg::res_t out_reg, out_next;

    logic        mem_we, mem_re;
    logic [pmx_pkg::ADDR_W-1:0] mem_addr;
    logic [pmx_pkg::WORD_W-1:0] mem_wdata, mem_rdata;

    logic [7:0]  orows_m1, ocols_m1;
    logic        in_rl, in_pe;
    logic [8:0]  div_x;
    logic [3:0]  div_s;
    logic [25:0] div_prod;
    logic [7:0]  div_q;
    logic [17:0] pos_full;
    logic [22:0] val_ext, rd_acc, acc_new;
    logic [15:0] rd_win, win_new;
    logic        first_px, greater, emit;
    logic [7:0]  dr, dc;
    logic [3:0]  dh, dw;
    logic [7:0]  area_full;
    logic [22:0] mag;
    logic [23:0] quot, avgv;
    pmx_pkg::res_t new_res;
    logic        out_free, out_fire;

    pmx_slot_mem u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_addr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_addr),
        .rd_data (mem_rdata)
    );

    always_comb
    begin
        orows_m1 = 8'(cfg.orows - 9'd1);
        ocols_m1 = 8'(cfg.ocols - 9'd1);
        in_rl    = row_end | plane_end | (col_cnt_reg == pmx_pkg::LAST_IN_COL);
        in_pe    = plane_end | (in_rl & (row_cnt_reg == pmx_pkg::LAST_IN_ROW));

        unique case (bstep_reg)
            2'd0:
            begin
                div_x = {1'b0, r_reg};
                div_s = cfg.sr;
            end
            2'd1:
            begin
                div_x = (({1'b0, r_reg} + 9'd1) <= {5'd0, cfg.kh}) ? 9'd0 :
                        ({1'b0, r_reg} + 9'd1 - {5'd0, cfg.kh} + {5'd0, cfg.sr} - 9'd1);
                div_s = cfg.sr;
            end
            2'd2:
            begin
                div_x = {1'b0, c_reg};
                div_s = cfg.sc;
            end
            default:
            begin
                div_x = (({1'b0, c_reg} + 9'd1) <= {5'd0, cfg.kw}) ? 9'd0 :
                        ({1'b0, c_reg} + 9'd1 - {5'd0, cfg.kw} + {5'd0, cfg.sc} - 9'd1);
                div_s = cfg.sc;
            end
        endcase
        div_prod = 26'(div_x) * 26'(step_recip[div_s]);
        div_q    = div_prod[23:16];

        pos_full = 18'(r_reg) * 18'(lrw_reg) + 18'(c_reg);

        val_ext  = {{7{val_reg[15]}}, val_reg};
        rd_acc   = mem_rdata[pmx_pkg::ACC_W-1:0];
        rd_win   = mem_rdata[pmx_pkg::WORD_W-1:pmx_pkg::ACC_W];
        first_px = (hs_reg == {4'd0, r_reg}) && (ws_reg == {4'd0, c_reg});
        greater  = $signed(val_ext) > $signed(rd_acc);
        if (first_px)
        begin
            acc_new = val_ext;
            win_new = pos_reg;
        end
        else if (cfg.mode == pmx_pkg::MODE_MAX)
        begin
            acc_new = greater ? val_ext : rd_acc;
            win_new = greater ? pos_reg : rd_win;
        end
        else
        begin
            acc_new = rd_acc + val_ext;
            win_new = rd_win;
        end
        emit = ((hs_reg + 12'(cfg.kh) - 12'd1 == {4'd0, r_reg}) || pe_reg) &&
               ((ws_reg + 12'(cfg.kw) - 12'd1 == {4'd0, c_reg}) || rl_reg);
        dr        = r_reg - hs_reg[7:0];
        dc        = c_reg - ws_reg[7:0];
        dh        = {1'b0, dr[2:0]} + 4'd1;
        dw        = {1'b0, dc[2:0]} + 4'd1;
        area_full = 8'(dh) * 8'(dw);

        mag  = cacc_reg[22] ? (23'd0 - cacc_reg) : cacc_reg;
        quot = prod_reg[52:29];
        avgv = cacc_reg[22] ? (24'd0 - quot) : quot;

        new_res.value      = (cfg.mode == pmx_pkg::MODE_AVG) ? avgv[15:0] : cacc_reg[15:0];
        new_res.win        = (cfg.mode == pmx_pkg::MODE_AVG) ? 16'd0 : cwin_reg;
        new_res.row        = cph_reg;
        new_res.col        = cpw_reg;
        new_res.plane_done = cpd_reg;
        new_res.run_last   = 1'b0;

        mem_addr  = {ph_reg[2:0], pw_reg};
        mem_wdata = {win_new, acc_new};
        out_fire  = out_valid_reg && !out_stall;
        out_free  = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        state_next     = state_reg;
        bstep_next     = bstep_reg;
        row_cnt_next   = row_cnt_reg;
        col_cnt_next   = col_cnt_reg;
        lrw_next       = lrw_reg;
        val_next       = val_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        rl_next        = rl_reg;
        pe_next        = pe_reg;
        ph_hi_next     = ph_hi_reg;
        ph_lo_next     = ph_lo_reg;
        pw_hi_next     = pw_hi_reg;
        pw_lo_next     = pw_lo_reg;
        ph_end_next    = ph_end_reg;
        pw_end_next    = pw_end_reg;
        ph_next        = ph_reg;
        pw_next        = pw_reg;
        hs_next        = hs_reg;
        ws_next        = ws_reg;
        ws_lo_next     = ws_lo_reg;
        pos_next       = pos_reg;
        last_next      = last_reg;
        cacc_next      = cacc_reg;
        cwin_next      = cwin_reg;
        cph_next       = cph_reg;
        cpw_next       = cpw_reg;
        cpd_next       = cpd_reg;
        area_next      = area_reg;
        prod_next      = prod_reg;
        have_next      = have_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_fire ? 1'b0 : out_valid_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    val_next   = pixel_value;
                    r_next     = row_cnt_reg;
                    c_next     = col_cnt_reg;
                    rl_next    = in_rl;
                    pe_next    = in_pe;
                    bstep_next = 2'd0;
                    state_next = S_BND;
                end
            end
            S_BND:
            begin
                unique case (bstep_reg)
                    2'd0:    ph_hi_next = div_q;
                    2'd1:    ph_lo_next = div_q;
                    2'd2:    pw_hi_next = div_q;
                    default: pw_lo_next = div_q;
                endcase
                bstep_next = bstep_reg + 2'd1;
                if (bstep_reg == 2'd3)
                begin
                    state_next = S_SET;
                end
            end
            S_SET:
            begin
                ph_end_next = (ph_hi_reg < orows_m1) ? ph_hi_reg : orows_m1;
                pw_end_next = (pw_hi_reg < ocols_m1) ? pw_hi_reg : ocols_m1;
                ph_next     = ph_lo_reg;
                pw_next     = pw_lo_reg;
                hs_next     = 12'(ph_lo_reg) * 12'(cfg.sr);
                ws_next     = 12'(pw_lo_reg) * 12'(cfg.sc);
                ws_lo_next  = 12'(pw_lo_reg) * 12'(cfg.sc);
                pos_next    = pos_full[15:0];
                if ((ph_lo_reg > ph_end_next) || (pw_lo_reg > pw_end_next))
                begin
                    state_next = S_END;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                mem_we    = 1'b1;
                cacc_next = acc_new;
                cwin_next = win_new;
                cph_next  = ph_reg;
                cpw_next  = pw_reg;
                cpd_next  = (ph_reg == orows_m1) && (pw_reg == ocols_m1);
                area_next = area_full[6:0];
                last_next = (ph_reg == ph_end_reg) && (pw_reg == pw_end_reg);
                if (pw_reg == pw_end_reg)
                begin
                    ph_next = ph_reg + 8'd1;
                    hs_next = hs_reg + 12'(cfg.sr);
                    pw_next = pw_lo_reg;
                    ws_next = ws_lo_reg;
                end
                else
                begin
                    pw_next = pw_reg + 8'd1;
                    ws_next = ws_reg + 12'(cfg.sc);
                end
                if (emit)
                begin
                    state_next = S_MUL;
                end
                else if (last_next)
                begin
                    state_next = S_END;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_MUL:
            begin
                prod_next  = 53'(mag) * 53'(area_recip[area_reg]);
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (!have_reg || out_free)
                begin
                    if (have_reg)
                    begin
                        out_next       = pend_reg;
                        out_valid_next = 1'b1;
                    end
                    pend_next  = new_res;
                    have_next  = 1'b1;
                    state_next = last_reg ? S_END : S_RD;
                end
            end
            S_END:
            begin
                if (!have_reg || out_free)
                begin
                    if (have_reg)
                    begin
                        out_next            = pend_reg;
                        out_next.run_last   = 1'b1;
                        out_next.plane_done = pend_reg.plane_done | pe_reg |
                                              (rl_reg & (pend_reg.row == orows_m1));
                        out_valid_next      = 1'b1;
                        have_next           = 1'b0;
                    end
                    if (rl_reg)
                    begin
                        lrw_next = {1'b0, c_reg} + 9'd1;
                    end
                    if (pe_reg)
                    begin
                        row_cnt_next = 8'd0;
                        col_cnt_next = 8'd0;
                    end
                    else if (rl_reg)
                    begin
                        row_cnt_next = r_reg + 8'd1;
                        col_cnt_next = 8'd0;
                    end
                    else
                    begin
                        col_cnt_next = c_reg + 8'd1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bstep_reg     <= 2'd0;
            row_cnt_reg   <= 8'd0;
            col_cnt_reg   <= 8'd0;
            lrw_reg       <= 9'd0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bstep_reg     <= bstep_next;
            row_cnt_reg   <= row_cnt_next;
            col_cnt_reg   <= col_cnt_next;
            lrw_reg       <= lrw_next;
            have_reg      <= have_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg    <= val_next;
        r_reg      <= r_next;
        c_reg      <= c_next;
        rl_reg     <= rl_next;
        pe_reg     <= pe_next;
        ph_hi_reg  <= ph_hi_next;
        ph_lo_reg  <= ph_lo_next;
        pw_hi_reg  <= pw_hi_next;
        pw_lo_reg  <= pw_lo_next;
        ph_end_reg <= ph_end_next;
        pw_end_reg <= pw_end_next;
        ph_reg     <= ph_next;
        pw_reg     <= pw_next;
        hs_reg     <= hs_next;
        ws_reg     <= ws_next;
        ws_lo_reg  <= ws_lo_next;
        pos_reg    <= pos_next;
        last_reg   <= last_next;
        cacc_reg   <= cacc_next;
        cwin_reg   <= cwin_next;
        cph_reg    <= cph_next;
        cpw_reg    <= cpw_next;
        cpd_reg    <= cpd_next;
        area_reg   <= area_next;
        prod_reg   <= prod_next;
        pend_reg   <= pend_next;
        out_reg    <= out_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

`default_nettype wire
